[src/assert_macros.svh]
// Assertion macros shared by the parser modules.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, suspended while reset is held.
`define CHECK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/lprp_pkg.sv]
// Types and constants of the length-prefixed request parser.
// No dependencies; imported by every module of the block.
package lprp_pkg;

    localparam logic [15:0] MAX_ARGS_RESET = 16'd1024;
    localparam int          QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        PH_COUNT   = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TAIL    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_COUNT   = 2'd0,
        KIND_LENGTH  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_STATUS  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_TOO_MANY  = 3'd2,
        ST_TRUNC_LEN = 3'd3,
        ST_TRUNC_PAY = 3'd4,
        ST_TRAILING  = 3'd5
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [15:0] arg_index;
        status_t     status;
        logic        is_last;
    } result_t;

    // Results produced by one accepted beat: num is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[src/lprp_parser.sv]
// Frame parsing state and per-beat result generation.
// Depends on lprp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lprp_parser
    import lprp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  logic [7:0]  in_byte,
    input  logic        frame_last,
    input  logic [15:0] max_args,
    output push_t       push
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] field_reg, field_next;
    logic [15:0] args_reg, args_next;
    logic [15:0] cur_reg, cur_next;
    logic [31:0] pay_reg, pay_next;
    status_t     err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COUNT;
            pos_reg   <= 2'd0;
            field_reg <= 32'd0;
            args_reg  <= 16'd0;
            cur_reg   <= 16'd0;
            pay_reg   <= 32'd0;
            err_reg   <= ST_OK;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            field_reg <= field_next;
            args_reg  <= args_next;
            cur_reg   <= cur_next;
            pay_reg   <= pay_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        logic [31:0] field_full;
        logic        data_vld;
        result_t     data_res;
        result_t     stat_res;
        status_t     st;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        field_next = field_reg;
        args_next  = args_reg;
        cur_next   = cur_reg;
        pay_next   = pay_reg;
        err_next   = err_reg;
        push       = '0;
        data_vld   = 1'b0;
        data_res   = '0;
        stat_res   = '0;
        st         = ST_OK;
        field_full = field_reg | ({24'd0, in_byte} << {pos_reg, 3'b000});

        if (take && err_reg == ST_OK) begin
            unique case (phase_reg)
                PH_COUNT: begin
                    if (pos_reg == 2'd3) begin
                        data_vld       = 1'b1;
                        data_res.kind  = KIND_COUNT;
                        data_res.value = field_full;
                        field_next     = 32'd0;
                        pos_next       = 2'd0;
                        if (field_full > {16'd0, max_args}) begin
                            err_next   = ST_TOO_MANY;
                            phase_next = PH_TAIL;
                        end else begin
                            args_next  = field_full[15:0];
                            cur_next   = 16'd0;
                            phase_next = (field_full[15:0] == 16'd0) ? PH_TAIL : PH_LENGTH;
                        end
                    end else begin
                        field_next = field_full;
                        pos_next   = pos_reg + 2'd1;
                    end
                end
                PH_LENGTH: begin
                    if (pos_reg == 2'd3) begin
                        data_vld           = 1'b1;
                        data_res.kind      = KIND_LENGTH;
                        data_res.value     = field_full;
                        data_res.arg_index = cur_reg;
                        field_next         = 32'd0;
                        pos_next           = 2'd0;
                        pay_next           = field_full;
                        if (field_full == 32'd0) begin
                            cur_next   = cur_reg + 16'd1;
                            args_next  = args_reg - 16'd1;
                            phase_next = (args_reg == 16'd1) ? PH_TAIL : PH_LENGTH;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end else begin
                        field_next = field_full;
                        pos_next   = pos_reg + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    data_vld           = 1'b1;
                    data_res.kind      = KIND_PAYLOAD;
                    data_res.value     = {24'd0, in_byte};
                    data_res.arg_index = cur_reg;
                    pay_next           = pay_reg - 32'd1;
                    if (pay_reg == 32'd1) begin
                        cur_next   = cur_reg + 16'd1;
                        args_next  = args_reg - 16'd1;
                        phase_next = (args_reg == 16'd1) ? PH_TAIL : PH_LENGTH;
                    end
                end
                PH_TAIL: begin
                    err_next = ST_TRAILING;
                end
                default: begin
                    err_next = ST_TRAILING;
                end
            endcase
        end

        if (take && frame_last) begin
            if (err_next != ST_OK) begin
                st = err_next;
            end else begin
                unique case (phase_next)
                    PH_COUNT:   st = ST_SHORT;
                    PH_LENGTH:  st = ST_TRUNC_LEN;
                    PH_PAYLOAD: st = ST_TRUNC_PAY;
                    default:    st = ST_OK;
                endcase
            end
            stat_res.kind    = KIND_STATUS;
            stat_res.status  = st;
            stat_res.is_last = 1'b1;
            // The frame is over; the next beat starts a fresh header.
            phase_next = PH_COUNT;
            pos_next   = 2'd0;
            field_next = 32'd0;
            args_next  = 16'd0;
            cur_next   = 16'd0;
            pay_next   = 32'd0;
            err_next   = ST_OK;
        end

        if (data_vld && take && frame_last) begin
            push.num    = 2'd2;
            push.first  = data_res;
            push.second = stat_res;
        end else if (data_vld) begin
            data_res.is_last = 1'b1;
            push.num         = 2'd1;
            push.first       = data_res;
        end else if (take && frame_last) begin
            push.num   = 2'd1;
            push.first = stat_res;
        end
    end

    `CHECK_RST(a_frame_end_clears, aclk, aresetn, (take && frame_last) |=> (phase_reg == PH_COUNT && err_reg == ST_OK && pos_reg == 2'd0), "parser state not cleared after frame end")
    `CHECK_RST(a_error_sticky, aclk, aresetn, (err_reg != ST_OK && !(take && frame_last)) |=> (err_reg == $past(err_reg)), "error code changed before frame end")
    `CHECK_RST(a_payload_pending, aclk, aresetn, (phase_reg == PH_PAYLOAD && err_reg == ST_OK) |-> (pay_reg != 32'd0 && args_reg != 16'd0), "payload phase without bytes or arguments left")

endmodule

[src/lprp_out_queue.sv]
// Four-entry result queue: takes up to two results per cycle, gives one per beat.
// Depends on lprp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lprp_out_queue
    import lprp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            entry_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_mem[rd_ptr_reg];
    // Room for the two results that one beat can cause.
    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            entry_mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            entry_mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    `CHECK_RST(a_no_overflow, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH), "result queue overflow")
    `CHECK_RST(a_push_needs_room, aclk, aresetn, (push.num != 2'd0) |-> room, "results pushed without room")
    `CHECK_RST(a_pop_only, aclk, aresetn, (pop && push.num == 2'd0) |=> (count_reg == $past(count_reg) - CNT_W'(1)), "queue count wrong after a pop")

endmodule

[src/length_prefixed_request_parser_unit.sv]
// Length-prefixed request parser: byte stream in, count/length/payload/status results out.
// Results are queued; if the queue was empty, the first is on m_ from the next cycle on.
// Throughput: one byte per cycle while s_tready shows room in the four-entry result queue;
// a frame's last byte that also yields data gives two queued results, which take two output beats.
// Reset (aresetn, synchronous, active low): parser and queue empty, max_args back to 1024.
// Depends on lprp_pkg, lprp_parser and lprp_out_queue.
module length_prefixed_request_parser_unit
    import lprp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // max_args
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // in_byte [7:0]
    input  logic        s_tlast,       // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // value [31:0], arg_index [47:32], status [50:48], zero
    output logic [1:0]  m_tuser,       // kind [1:0]
    output logic        m_tlast        // is_last
);

    logic [15:0] max_args_reg;
    logic        take;
    push_t       push;
    result_t     out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_args_reg <= MAX_ARGS_RESET;
        end else if (cfg_wr_en) begin
            max_args_reg <= cfg_wr_data;
        end
    end

    assign take = s_tvalid && s_tready;

    lprp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .in_byte    (s_tdata),
        .frame_last (s_tlast),
        .max_args   (max_args_reg),
        .push       (push)
    );

    lprp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.status, out_res.arg_index, out_res.value};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.is_last;

endmodule

[test/tb_top.sv]
// Self-checking testbench for length_prefixed_request_parser_unit.
// Drives request frames with random gaps and output stalls and checks every result beat.
// Depends on lprp_pkg and the parser RTL only.
module tb_top;
    import lprp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 6;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;      // value [31:0], arg_index [47:32], status [50:48], zero
    logic [1:0]  m_tuser;      // kind [1:0]
    logic        m_tlast;      // is_last

    length_prefixed_request_parser_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Parser state as the testbench tracks it.
    logic [15:0] arg_limit = MAX_ARGS_RESET;
    phase_t      rq_phase = PH_COUNT;
    logic [1:0]  rq_byte_pos = '0;
    logic [31:0] rq_field = '0;
    logic [15:0] rq_args_left = '0;
    logic [15:0] rq_arg = '0;
    logic [31:0] rq_payload_left = '0;
    status_t     rq_error = ST_OK;

    result_t     parser_results_due[$];
    logic [7:0]  frame_q[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_tick = 0;

    function automatic result_t make_result(kind_t k, logic [31:0] v, logic [15:0] idx,
                                            status_t st);
        result_t r;
        r.kind      = k;
        r.value     = v;
        r.arg_index = idx;
        r.status    = st;
        r.is_last   = 1'b0;
        return r;
    endfunction

    // Adds one byte to the little-endian field; true once four bytes are in.
    function automatic bit take_field_byte(logic [7:0] b);
        rq_field = rq_field | (32'(b) << (8 * rq_byte_pos));
        if (rq_byte_pos == 2'd3) begin
            rq_byte_pos = 2'd0;
            return 1'b1;
        end
        rq_byte_pos = rq_byte_pos + 2'd1;
        return 1'b0;
    endfunction

    function automatic void next_argument();
        rq_arg       = rq_arg + 16'd1;
        rq_args_left = rq_args_left - 16'd1;
        rq_phase     = (rq_args_left == 16'd0) ? PH_TAIL : PH_LENGTH;
    endfunction

    // Works out the results of one accepted request byte and queues them.
    function automatic void parse_request_byte(logic [7:0] b, logic last);
        result_t     res[2];
        int          n;
        logic [31:0] word;
        status_t     st;
        n = 0;
        if (rq_error != ST_OK) begin
            // Dropping bytes until the frame ends.
        end else if (rq_phase == PH_COUNT) begin
            if (take_field_byte(b)) begin
                word = rq_field;
                rq_field = '0;
                res[n] = make_result(KIND_COUNT, word, 16'd0, ST_OK);
                n++;
                if (word > {16'd0, arg_limit}) begin
                    rq_error = ST_TOO_MANY;
                    rq_phase = PH_TAIL;
                end else begin
                    rq_args_left = word[15:0];
                    rq_arg = '0;
                    rq_phase = (rq_args_left == 16'd0) ? PH_TAIL : PH_LENGTH;
                end
            end
        end else if (rq_phase == PH_LENGTH) begin
            if (take_field_byte(b)) begin
                word = rq_field;
                rq_field = '0;
                res[n] = make_result(KIND_LENGTH, word, rq_arg, ST_OK);
                n++;
                rq_payload_left = word;
                if (word == 32'd0)
                    next_argument();
                else
                    rq_phase = PH_PAYLOAD;
            end
        end else if (rq_phase == PH_PAYLOAD) begin
            res[n] = make_result(KIND_PAYLOAD, {24'd0, b}, rq_arg, ST_OK);
            n++;
            rq_payload_left = rq_payload_left - 32'd1;
            if (rq_payload_left == 32'd0)
                next_argument();
        end else begin
            rq_error = ST_TRAILING;
        end

        if (last) begin
            if (rq_error != ST_OK)
                st = rq_error;
            else if (rq_phase == PH_COUNT)
                st = ST_SHORT;
            else if (rq_phase == PH_LENGTH)
                st = ST_TRUNC_LEN;
            else if (rq_phase == PH_PAYLOAD)
                st = ST_TRUNC_PAY;
            else
                st = ST_OK;
            res[n] = make_result(KIND_STATUS, 32'd0, 16'd0, st);
            n++;
            rq_phase        = PH_COUNT;
            rq_byte_pos     = '0;
            rq_field        = '0;
            rq_args_left    = '0;
            rq_arg          = '0;
            rq_payload_left = '0;
            rq_error        = ST_OK;
        end

        if (n > 0)
            res[n-1].is_last = 1'b1;
        for (int i = 0; i < n; i++)
            parser_results_due.insert(parser_results_due.size(), res[i]);
    endfunction

    // Result checker: every output beat is matched against the oldest pending result.
    always @(posedge aclk) begin
        result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (parser_results_due.size() == 0) begin
                $error("unexpected result beat: kind %0d value %0h", m_tuser, m_tdata[31:0]);
                mismatch_count++;
            end else begin
                due = parser_results_due.pop_front();
                if (m_tuser !== due.kind) begin
                    $error("kind: expected %0d, actual %0d", due.kind, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] !== due.value) begin
                    $error("value: expected %0h, actual %0h", due.value, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[47:32] !== due.arg_index) begin
                    $error("arg_index: expected %0d, actual %0d", due.arg_index,
                           m_tdata[47:32]);
                    mismatch_count++;
                end
                if (m_tdata[50:48] !== due.status) begin
                    $error("status: expected %0d, actual %0d", due.status, m_tdata[50:48]);
                    mismatch_count++;
                end
                if (m_tlast !== due.is_last) begin
                    $error("is_last: expected %0d, actual %0d", due.is_last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver switches between stall patterns, one of them never stalling.
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(30, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_tick % 5) < 2);
        endcase
    end

    // Sends one byte; called at a falling edge and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        parse_request_byte(b, last);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        bytes_sent += frame_q.size();
    endtask

    // Waits until every pending result has come out and the parser has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (parser_results_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        wait_idle();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        arg_limit = v;
        @(negedge aclk);
    endtask

    function automatic void append_byte(logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endfunction

    function automatic void push_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            append_byte(w[8*i +: 8]);
    endfunction

    function automatic logic [7:0] random_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_arg_count();
        int unsigned hi;
        if (arg_limit == 16'd0)
            return 0;
        hi = (arg_limit < 16'd4) ? arg_limit : 4;
        return $urandom_range(0, hi);
    endfunction

    // Builds a well-formed request; with huge_len the last argument announces a
    // length far beyond what follows, so the frame ends inside its payload.
    function automatic void build_request(int unsigned n_args, bit huge_len);
        logic [31:0] len;
        int unsigned n_pay;
        frame_q.delete();
        push_word(n_args);
        for (int unsigned a = 0; a < n_args; a++) begin
            if (huge_len && a == n_args - 1)
                len = $urandom | 32'h8000_0000;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(7, 24);
            else
                len = $urandom_range(0, 6);
            push_word(len);
            n_pay = (huge_len && a == n_args - 1) ? $urandom_range(0, 4) : len;
            repeat (n_pay) append_byte(random_byte());
        end
    endfunction

    task automatic random_frame();
        int unsigned pick;
        int unsigned k;
        int unsigned n_args;
        bit          huge;
        logic [31:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            build_request(pick_arg_count(), 1'b0);
            send_frame();
        end else if (pick < 70) begin
            build_request(pick_arg_count(), 1'b0);
            k = $urandom_range(1, 3);
            repeat (k) append_byte(random_byte());
            send_frame();
        end else if (pick < 80) begin
            if (arg_limit == 16'hFFFF || $urandom_range(0, 1) == 1)
                cnt = $urandom | 32'h0001_0000;
            else
                cnt = {16'd0, arg_limit} + 32'd1 + 32'($urandom_range(0, 3));
            frame_q.delete();
            push_word(cnt);
            k = $urandom_range(0, 5);
            repeat (k) append_byte(random_byte());
            send_frame();
        end else if (pick < 95) begin
            n_args = pick_arg_count();
            huge = (n_args > 0) && ($urandom_range(0, 2) == 0);
            build_request(n_args, huge);
            if (!huge) begin
                k = $urandom_range(1, frame_q.size() - 1);
                frame_q = frame_q[0:k-1];
            end
            send_frame();
        end else begin
            // Raw noise, with frame ends scattered inside.
            k = $urandom_range(1, 12);
            for (int unsigned i = 0; i < k; i++)
                send_byte(random_byte(), (i == k - 1) || ($urandom_range(0, 5) == 0));
            bytes_sent += k;
        end
    endtask

    // The limit after reset must already be 1024.
    task automatic test_reset_limit();
        frame_q.delete();
        push_word(32'd1024);
        send_frame();
        frame_q.delete();
        push_word(32'd1025);
        append_byte(8'hFF);
        send_frame();
        wait_idle();
    endtask

    task automatic test_frame_status();
        // Header cut after two bytes.
        frame_q.delete();
        append_byte(8'h00);
        append_byte(8'hFF);
        send_frame();
        // Zero count, then a zero count followed by trailing bytes.
        frame_q.delete();
        push_word(32'd0);
        send_frame();
        frame_q.delete();
        push_word(32'd0);
        append_byte(8'h00);
        append_byte(8'hFF);
        send_frame();
        // Two arguments, the first of zero length, payload at both byte extremes.
        frame_q.delete();
        push_word(32'd2);
        push_word(32'd0);
        push_word(32'd2);
        append_byte(8'h00);
        append_byte(8'hFF);
        send_frame();
        // Maximum length, frame ends inside the payload.
        frame_q.delete();
        push_word(32'd1);
        push_word(32'hFFFF_FFFF);
        append_byte(8'h5A);
        send_frame();
        // Frame ends inside a length field.
        frame_q.delete();
        push_word(32'd1);
        append_byte(8'h01);
        append_byte(8'h00);
        send_frame();
        wait_idle();
    endtask

    task automatic test_limit_extremes();
        write_limit(16'd0);
        frame_q.delete();
        push_word(32'd0);
        send_frame();
        frame_q.delete();
        push_word(32'd1);
        send_frame();
        write_limit(16'hFFFF);
        frame_q.delete();
        push_word(32'd65535);
        send_frame();
        frame_q.delete();
        push_word(32'hFFFF_FFFF);
        send_frame();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [15:0] v;
        int unsigned target;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: v = 16'($urandom_range(1, 6));
                1: v = 16'hFFFF;
                2: v = 16'd0;
                3: v = MAX_ARGS_RESET;
                4: v = 16'($urandom_range(0, 65535));
                default: v = 16'd2;
            endcase
            write_limit(v);
            target = bytes_sent + 120;
            while (bytes_sent < target)
                random_frame();
            wait_idle();
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_limit();
        test_frame_status();
        test_limit_extremes();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (parser_results_due.size() != 0) begin
            $error("%0d results never arrived", parser_results_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[length_prefixed_request_parser_unit.f]
+incdir+src
src/lprp_pkg.sv
src/lprp_parser.sv
src/lprp_out_queue.sv
src/length_prefixed_request_parser_unit.sv
test/tb_top.sv
